// ===== hdl/typed_message_deframer_core_assert.svh =====
// Assertion macros shared by the deframer checker.
// Plain text macros only; no dependencies.
`ifndef TYPED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define TYPED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tmd_pkg.sv =====
// Shared types and constants of the typed message deframer.
// No dependencies; imported by tmd_cmp and the deframer core.
package tmd_pkg;

  localparam int unsigned MAX_LEN_DEF = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CONSOLE_CODE = 3'd0;
  localparam logic [2:0] CFG_BIN_COUNT    = 3'd1;
  localparam logic [2:0] CFG_SIZE_ONE     = 3'd2;
  localparam logic [2:0] CFG_SIZE_TWO     = 3'd3;
  localparam logic [2:0] CFG_SIZE_THREE   = 3'd4;
  localparam logic [2:0] CFG_SIZE_FOUR    = 3'd5;
  localparam logic [2:0] CFG_SIZE_FIVE    = 3'd6;

  localparam logic [7:0] CONSOLE_CODE_RST = 8'd255;
  localparam logic [2:0] BIN_COUNT_RST    = 3'd6;
  localparam int unsigned NUM_SIZES       = 5;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_DISCARD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPE_CON,
    ST_TYPE_BIN,
    ST_FULL_CHK,
    ST_END_CHK,
    ST_LF_CHK,
    ST_RD,
    ST_EMIT,
    ST_OWAIT
  } tmd_state_e;

  typedef struct packed {
    logic eq;
    logic lt;
  } tmd_cmp_t;

endpackage

// ===== hdl/tmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tmd_cmp.sv =====
// Shared 8-bit compare unit of the deframer sequencer.
// Depends on tmd_pkg for the result struct.
module tmd_cmp (
  input  logic [7:0]        a_i,
  input  logic [7:0]        b_i,
  output tmd_pkg::tmd_cmp_t res_o
);
  import tmd_pkg::*;

  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.lt = (a_i < b_i);
  end

endmodule

// ===== hdl/typed_message_deframer_core.sv =====
// Channel  | dir | handshake              | payload
// rx       | in  | rx_valid_i/rx_ready_o  | rx_byte_i
// res      | out | res_valid_o/res_ready_i| result_kind_o, message_type_o, data_byte_o, last_o
// cfg      | in  | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// One shared compare unit is stepped by a small sequencer, one compare per cycle.
// A type byte passes the console and binary type checks, a payload byte the full and terminator checks.
// Draining a completed message steps each byte through the registered RAM read (ST_RD),
// the output register (ST_EMIT) and the wait for res_ready_i (ST_OWAIT).
// rx_ready_o is high only in the idle state; reset is asynchronous, active low.
// Depends on tmd_pkg, tmd_cmp and tmd_ram.
module typed_message_deframer_core #(
  parameter int unsigned MAX_LEN = tmd_pkg::MAX_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       result_kind_o,
  output logic [7:0] message_type_o,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import tmd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  tmd_state_e state_q, state_d;

  logic [7:0]    console_code_q;
  logic [2:0]    bin_count_q;
  logic [5:0]    size_q [NUM_SIZES];

  logic [7:0]    ch_q, ch_d;
  logic          receiving_q, receiving_d;
  logic          console_q, console_d;
  logic [7:0]    cur_type_q, cur_type_d;
  logic [5:0]    exp_q, exp_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic          res_valid_q, res_valid_d;
  logic          kind_q, kind_d;
  logic [7:0]    type_q, type_d;
  logic [7:0]    data_q, data_d;
  logic          last_q, last_d;

  logic [7:0]    cmp_a, cmp_b;
  tmd_cmp_t      cmp_res;
  logic          mem_we, mem_re;
  logic [7:0]    mem_rdata;
  logic [5:0]    sel_size;

  tmd_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  tmd_ram #(
    .Width (8),
    .Depth (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ch_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      console_code_q <= CONSOLE_CODE_RST;
      bin_count_q    <= BIN_COUNT_RST;
      for (int i = 0; i < NUM_SIZES; i++) begin
        size_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONSOLE_CODE: console_code_q <= cfg_wdata_i;
        CFG_BIN_COUNT:    bin_count_q    <= cfg_wdata_i[2:0];
        CFG_SIZE_ONE:     size_q[0]      <= cfg_wdata_i[5:0];
        CFG_SIZE_TWO:     size_q[1]      <= cfg_wdata_i[5:0];
        CFG_SIZE_THREE:   size_q[2]      <= cfg_wdata_i[5:0];
        CFG_SIZE_FOUR:    size_q[3]      <= cfg_wdata_i[5:0];
        CFG_SIZE_FIVE:    size_q[4]      <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      receiving_q <= 1'b0;
      console_q   <= 1'b0;
      cur_type_q  <= '0;
      exp_q       <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      receiving_q <= receiving_d;
      console_q   <= console_d;
      cur_type_q  <= cur_type_d;
      exp_q       <= exp_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    kind_q <= kind_d;
    type_q <= type_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  // Types above five have no size register and read as size zero.
  always_comb begin
    sel_size = '0;
    if (ch_q != 8'd0 && ch_q <= 8'd5) begin
      sel_size = size_q[3'(ch_q - 8'd1)];
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    receiving_d = receiving_q;
    console_d   = console_q;
    cur_type_d  = cur_type_q;
    exp_d       = exp_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    res_valid_d = res_valid_q;
    kind_d      = kind_q;
    type_d      = type_q;
    data_d      = data_q;
    last_d      = last_q;
    cmp_a       = '0;
    cmp_b       = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rx_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          ch_d    = rx_byte_i;
          state_d = receiving_q ? ST_FULL_CHK : ST_TYPE_CON;
        end
      end
      ST_TYPE_CON: begin
        cmp_a = ch_q;
        cmp_b = console_code_q;
        if (cmp_res.eq) begin
          receiving_d = 1'b1;
          console_d   = 1'b1;
          cur_type_d  = ch_q;
          exp_d       = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_TYPE_BIN;
        end
      end
      ST_TYPE_BIN: begin
        cmp_a = ch_q;
        cmp_b = 8'(bin_count_q);
        if (cmp_res.lt && ch_q != 8'd0 && sel_size != 6'd0) begin
          receiving_d = 1'b1;
          console_d   = 1'b0;
          cur_type_d  = ch_q;
          exp_d       = sel_size;
          count_d     = '0;
        end
        state_d = ST_IDLE;
      end
      ST_FULL_CHK: begin
        cmp_a = 8'(count_q);
        cmp_b = 8'(MAX_LEN);
        if (!cmp_res.lt) begin
          // Buffer full: drop the byte and report the discarded frame.
          res_valid_d = 1'b1;
          kind_d      = KIND_DISCARD;
          type_d      = cur_type_q;
          data_d      = '0;
          last_d      = 1'b1;
          receiving_d = 1'b0;
          console_d   = 1'b0;
          cur_type_d  = '0;
          exp_d       = '0;
          count_d     = '0;
          state_d     = ST_OWAIT;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          state_d = ST_END_CHK;
        end
      end
      ST_END_CHK: begin
        if (console_q) begin
          cmp_a = ch_q;
          cmp_b = CHAR_CR;
          state_d = ST_LF_CHK;
        end else begin
          cmp_a = 8'(count_q);
          cmp_b = 8'(exp_q);
          state_d = ST_IDLE;
        end
        if (cmp_res.eq) begin
          rd_idx_d = '0;
          state_d  = ST_RD;
        end
      end
      ST_LF_CHK: begin
        cmp_a = ch_q;
        cmp_b = CHAR_LF;
        if (cmp_res.eq) begin
          rd_idx_d = '0;
          state_d  = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmp_a       = 8'(CW'(rd_idx_q) + CW'(1));
        cmp_b       = 8'(count_q);
        res_valid_d = 1'b1;
        kind_d      = KIND_DATA;
        type_d      = cur_type_q;
        data_d      = mem_rdata;
        last_d      = cmp_res.eq;
        state_d     = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (res_ready_i) begin
          res_valid_d = 1'b0;
          if (last_q) begin
            receiving_d = 1'b0;
            console_d   = 1'b0;
            cur_type_d  = '0;
            exp_d       = '0;
            count_d     = '0;
            state_d     = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
            state_d  = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o    = res_valid_q;
  assign result_kind_o  = kind_q;
  assign message_type_o = type_q;
  assign data_byte_o    = data_q;
  assign last_o         = last_q;

endmodule

// ===== hdl/tmd_chk.sv =====
// Port-level checker for the typed message deframer, bound to the top level.
// Depends on typed_message_deframer_core_assert.svh for the assertion macros.
`include "typed_message_deframer_core_assert.svh"

module tmd_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic       res_valid_o,
  input logic       res_ready_i,
  input logic       result_kind_o,
  input logic [7:0] data_byte_o,
  input logic       last_o
);

  // Every accepted byte needs at least one compare step before the next request.
  `TMD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, rx_valid_i && rx_ready_o, !rx_ready_o, "input accepted on consecutive cycles")

  // Input and output never both open: results drain before new bytes are taken.
  `TMD_ASSERT_NOW(a_no_rx_while_result, clk_i, rst_ni, res_valid_o, !rx_ready_o, "input ready while a result is pending")

  // A discard is a single result with no data.
  `TMD_ASSERT_NOW(a_discard_shape, clk_i, rst_ni, res_valid_o && result_kind_o, last_o && data_byte_o == 8'd0, "malformed discard result")

  `TMD_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o && $stable(data_byte_o) && $stable(last_o), "stalled result changed")

endmodule

bind typed_message_deframer_core tmd_chk u_tmd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_valid_i),
  .rx_ready_o    (rx_ready_o),
  .res_valid_o   (res_valid_o),
  .res_ready_i   (res_ready_i),
  .result_kind_o (result_kind_o),
  .data_byte_o   (data_byte_o),
  .last_o        (last_o)
);
